### hdl/pixrq_pkg.sv
// Types, constants and a helper function shared by the pixel requantize bit packer.
`timescale 1ns / 1ps
`default_nettype none

package pixrq_pkg;

    // Field widths of the stream and of the configuration register.
    localparam int PIXEL_W = 8;
    localparam int BYTE_W  = 8;
    localparam int LEVEL_W = 7;
    localparam int FILL_W  = 3;
    localparam int TOTAL_W = 4;
    localparam int SHIFT_W = 5;
    localparam int PROD_W  = PIXEL_W + LEVEL_W;
    localparam int WIN_W   = 2 * BYTE_W;

    // Requantization divides by a power of two, so the divide is a shift.
    localparam int SCALE_RANGE = 256;
    localparam int SCALE_SHIFT = $clog2(SCALE_RANGE);

    // Gray level after reset.
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd127;

    // Result queue: each pixel pushes at most two bytes.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // One input item.
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               last_pixel;
    } pix_in_t;

    // One result item.
    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              last_of_run;
    } pix_out_t;

    // Bytes handed from the packer to the result queue in one cycle.
    typedef struct packed {
        logic [1:0] cnt;
        pix_out_t   first;
        pix_out_t   second;
    } pix_push_t;

    // Number of significant bits of the gray level, 0 to 7.
    function automatic logic [FILL_W-1:0] bit_length(input logic [LEVEL_W-1:0] v);
        logic [FILL_W-1:0] n;
        n = '0;
        for (int i = 0; i < LEVEL_W; i++)
        begin
            if (v[i])
            begin
                n = FILL_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### hdl/pixrq_pack.sv
// Input register, requantizer and byte accumulator of the bit packer.
`timescale 1ns / 1ps
`default_nettype none

module pixrq_pack (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire pixrq_pkg::pix_in_t                in_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pixrq_pkg::LEVEL_W-1:0]     cfg_data,
    input  wire logic                              room,
    output pixrq_pkg::pix_push_t                   push
);

    logic                                  item_valid_reg;
    pixrq_pkg::pix_in_t                    item_reg;
    logic [pixrq_pkg::LEVEL_W-1:0]         level_reg;
    logic [pixrq_pkg::BYTE_W-1:0]          acc_reg;
    logic [pixrq_pkg::BYTE_W-1:0]          acc_next;
    logic [pixrq_pkg::FILL_W-1:0]          filled_reg;
    logic [pixrq_pkg::FILL_W-1:0]          filled_next;

    logic                                  advance;
    logic [pixrq_pkg::FILL_W-1:0]          code_len;
    logic [pixrq_pkg::PROD_W-1:0]          product;
    logic [pixrq_pkg::LEVEL_W-1:0]         code;
    logic [pixrq_pkg::LEVEL_W:0]           code_mask;
    logic [pixrq_pkg::TOTAL_W-1:0]         total;
    logic [pixrq_pkg::SHIFT_W-1:0]         shift_amt;
    logic [pixrq_pkg::WIN_W-1:0]           window;
    logic                                  full;
    logic                                  flush;
    logic [pixrq_pkg::BYTE_W-1:0]          acc_mid;
    logic [pixrq_pkg::FILL_W-1:0]          filled_mid;

    // The configuration register takes every write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= pixrq_pkg::LEVEL_RESET;
        end
        else if (cfg_valid)
        begin
            level_reg <= cfg_data;
        end
    end

    // The held pixel moves on whenever the result queue has room for two bytes.
    assign advance  = item_valid_reg && room;
    assign in_stall = item_valid_reg && !room;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= in_data;
        end
    end

    // Requantize: pixel times level over the scale range, kept to its code width.
    always_comb
    begin
        code_len  = pixrq_pkg::bit_length(level_reg);
        product   = pixrq_pkg::PROD_W'(item_reg.pixel) * pixrq_pkg::PROD_W'(level_reg);
        code_mask = ((pixrq_pkg::LEVEL_W + 1)'(1) << code_len)
                    - (pixrq_pkg::LEVEL_W + 1)'(1);
        code      = pixrq_pkg::LEVEL_W'(product >> pixrq_pkg::SCALE_SHIFT)
                    & code_mask[pixrq_pkg::LEVEL_W-1:0];
    end

    // Place the new code right under the pending bits in a two-byte window.
    always_comb
    begin
        total      = pixrq_pkg::TOTAL_W'(filled_reg) + pixrq_pkg::TOTAL_W'(code_len);
        shift_amt  = pixrq_pkg::SHIFT_W'(pixrq_pkg::WIN_W) - pixrq_pkg::SHIFT_W'(total);
        window     = {acc_reg, {pixrq_pkg::BYTE_W{1'b0}}}
                     | (pixrq_pkg::WIN_W'(code) << shift_amt);
        full       = total >= pixrq_pkg::TOTAL_W'(pixrq_pkg::BYTE_W);
        acc_mid    = full ? window[pixrq_pkg::BYTE_W-1:0]
                          : window[pixrq_pkg::WIN_W-1:pixrq_pkg::BYTE_W];
        filled_mid = full ? pixrq_pkg::FILL_W'(total - pixrq_pkg::TOTAL_W'(pixrq_pkg::BYTE_W))
                          : total[pixrq_pkg::FILL_W-1:0];
        flush      = item_reg.last_pixel && (filled_mid != '0);
    end

    // Bytes produced by this pixel: a completed byte, then a padded flush byte.
    always_comb
    begin
        push.second.packed_byte = acc_mid;
        push.second.last_of_run = 1'b1;
        push.cnt                = 2'd0;
        if (full)
        begin
            push.first.packed_byte = window[pixrq_pkg::WIN_W-1:pixrq_pkg::BYTE_W];
            push.first.last_of_run = !flush;
        end
        else
        begin
            push.first.packed_byte = acc_mid;
            push.first.last_of_run = 1'b1;
        end
        if (advance)
        begin
            push.cnt = 2'(full) + 2'(flush);
        end
    end

    // Accumulator state after this pixel.
    always_comb
    begin
        acc_next    = acc_reg;
        filled_next = filled_reg;
        if (advance)
        begin
            acc_next    = flush ? '0 : acc_mid;
            filled_next = flush ? '0 : filled_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            filled_reg <= '0;
        end
        else
        begin
            acc_reg    <= acc_next;
            filled_reg <= filled_next;
        end
    end

endmodule

`default_nettype wire

### hdl/pixrq_fifo.sv
// Four-entry result queue; per cycle up to two bytes in, one out if unstalled.
`timescale 1ns / 1ps
`default_nettype none

module pixrq_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pixrq_pkg::pix_push_t  push,
    output logic                       room,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output pixrq_pkg::pix_out_t        out_data
);

    pixrq_pkg::pix_out_t               mem_reg [pixrq_pkg::FIFO_DEPTH];
    logic [pixrq_pkg::PTR_W-1:0]       wr_ptr_reg;
    logic [pixrq_pkg::PTR_W-1:0]       wr_ptr_next;
    logic [pixrq_pkg::PTR_W-1:0]       rd_ptr_reg;
    logic [pixrq_pkg::PTR_W-1:0]       rd_ptr_next;
    logic [pixrq_pkg::CNT_W-1:0]       count_reg;
    logic [pixrq_pkg::CNT_W-1:0]       count_next;
    logic [pixrq_pkg::PTR_W-1:0]       wr_ptr_plus1;
    logic                              pop;

    // Room for a full pair of bytes, judged on the registered count only.
    assign room      = count_reg <= pixrq_pkg::CNT_W'(pixrq_pkg::FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign wr_ptr_plus1 = wr_ptr_reg + pixrq_pkg::PTR_W'(1);

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + pixrq_pkg::PTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + pixrq_pkg::PTR_W'(pop);
        count_next  = count_reg + pixrq_pkg::CNT_W'(push.cnt) - pixrq_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage writes: first byte at the write pointer, second right after it.
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

`default_nettype wire

### hdl/pixel_requantize_bit_packer.sv
// Top level of the pixel requantize bit packer.
// A pixel is held in the input register, then its bytes are written to the result queue.
// Throughput: one pixel per cycle while the queue has room for two; the single output byte
// per cycle is the limit when a pixel yields two bytes, which a four-entry queue absorbs.
// Reset: rst_n clears the accumulator, the queue and the input register and sets the
// gray level to 127; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module pixel_requantize_bit_packer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire pixrq_pkg::pix_in_t                in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output pixrq_pkg::pix_out_t                    out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pixrq_pkg::LEVEL_W-1:0]     cfg_data
);

    pixrq_pkg::pix_push_t push;
    logic                 room;

    // Requantizer and byte accumulator.
    pixrq_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .room      (room),
        .push      (push)
    );

    // Result queue toward the output channel.
    pixrq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### hdl/pixrq_checker.sv
// Port-level checker for the pixel requantize bit packer and its bind.
`timescale 1ns / 1ps
`default_nettype none

module pixrq_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_stall,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire pixrq_pkg::pix_out_t               out_data
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // Nothing is offered right after reset.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result offered right after reset");

    // A byte not marked last of its run is followed at once by another offered byte.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last_of_run |=> out_valid)
        else $error("run of bytes broken");

    // The input is held back only while results are waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending result");

endmodule

bind pixel_requantize_bit_packer pixrq_checker u_pixrq_checker (.*);

`default_nettype wire
